@@ hdl/b2da_pkg.sv @@
// Package for the binary to decimal ASCII converter.
// Holds item structs, sequencer states, shared-unit control and ASCII codes.
// No dependencies.
package b2da_pkg;

   localparam int unsigned VALUE_W = 64;

   // ASCII codes used on the result side
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Input item
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               signed_mode;
   } req_type;

   // Result item (one character)
   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } rsp_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // Commands from the sequencer to the shift/add-3 unit
   typedef struct packed {
      logic load;
      logic step;
      logic digit_shift;
   } dabble_ctl_type;

endpackage

@@ hdl/binary_to_decimal_ascii_core.sv @@
// Top level of the binary to decimal ASCII converter: sequencer and outputs.
// Depends on b2da_pkg and b2da_dabble.
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+---------------------------------
//  request  | start, busy, req_data       | taken when start & !busy
//  response | rsp_strobe, rsp_data        | one strobe per character, no stall
//
// An item runs one shift/add-3 step per value bit in the shared unit, then
// a sign step when negative, then a digit scan over DIGITS digits
// (leading zeros are skipped silently). Characters leave a registered
// output in the cycle after they are found, so the last one shows in the
// first idle cycle. Reset returns the sequencer to idle and drops the
// strobe. The receiver cannot stall; busy stays high for the whole item.
module binary_to_decimal_ascii_core #(
   parameter int VALUE_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  b2da_pkg::req_type req_data,
   output logic              rsp_strobe,
   output b2da_pkg::rsp_type rsp_data
);

   // decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103)
   localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);

   b2da_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic                     started_ff, started_in;
   logic                     strobe_ff, strobe_in;
   b2da_pkg::rsp_type        data_ff, data_in;
   b2da_pkg::dabble_ctl_type ctl;
   logic [VALUE_BITS-1:0]    raw;
   logic [VALUE_BITS-1:0]    mag;
   logic                     neg_req;
   logic [3:0]               top_digit;
   logic                     digit_last;

   // magnitude of the incoming value
   assign raw     = req_data.value[VALUE_BITS-1:0];
   assign neg_req = req_data.signed_mode & raw[VALUE_BITS-1];
   assign mag     = neg_req ? (~raw + 1'b1) : raw;

   assign digit_last = (cnt_ff == CNT_W'(DIGITS - 1));

   b2da_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_dabble (
      .clock     (clock),
      .ctl       (ctl),
      .load_mag  (mag),
      .top_digit (top_digit)
   );

   // sequencer: next state and outputs
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      neg_in          = neg_ff;
      started_in      = started_ff;
      strobe_in       = 1'b0;
      data_in         = data_ff;
      ctl             = '0;
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (start) begin
               ctl.load   = 1'b1;
               neg_in     = neg_req;
               started_in = 1'b0;
               cnt_in     = '0;
               state_in   = b2da_pkg::ST_CONVERT;
            end
         end
         b2da_pkg::ST_CONVERT: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
               cnt_in   = '0;
               state_in = neg_ff ? b2da_pkg::ST_SIGN : b2da_pkg::ST_EMIT;
            end
         end
         b2da_pkg::ST_SIGN: begin
            strobe_in         = 1'b1;
            data_in.text_char = b2da_pkg::ASCII_MINUS;
            data_in.last_char = 1'b0;
            state_in          = b2da_pkg::ST_EMIT;
         end
         b2da_pkg::ST_EMIT: begin
            // emit once a nonzero digit was seen, and always the last digit
            ctl.digit_shift = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            if (started_ff || (top_digit != 4'd0) || digit_last) begin
               strobe_in         = 1'b1;
               started_in        = 1'b1;
               data_in.text_char = b2da_pkg::ASCII_ZERO + {4'b0000, top_digit};
               data_in.last_char = digit_last;
            end
            if (digit_last) begin
               state_in = b2da_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = b2da_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= b2da_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // counters, flags and output payload
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
      data_ff    <= data_in;
   end

   assign busy       = (state_ff != b2da_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;

endmodule

@@ hdl/b2da_dabble.sv @@
// Shared shift/add-3 unit: binary shift register plus BCD digit register.
// Loads a magnitude, runs one double-dabble step per command, then shifts
// digits out most significant first. Depends on b2da_pkg.
module b2da_dabble #(
   parameter int VALUE_BITS = 64,
   parameter int DIGITS     = 20
) (
   input  logic                       clock,
   input  b2da_pkg::dabble_ctl_type   ctl,
   input  logic [VALUE_BITS-1:0]      load_mag,
   output logic [3:0]                 top_digit
);

   localparam int BCD_W = DIGITS * 4;

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      bcd_adj;

   // add 3 to every digit of 5 or more (digits are independent)
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // next value of the shift registers
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctl.load) begin
         bin_in = load_mag;
         bcd_in = '0;
      end else if (ctl.step) begin
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
      end else if (ctl.digit_shift) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'b0000};
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

@@ hdl/b2da_checker.sv @@
// Port-level checker for the binary to decimal ASCII converter, bound to the
// top level. Depends on b2da_pkg and binary_to_decimal_ascii_core.
module b2da_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input b2da_pkg::rsp_type rsp_data,
   input logic              rsp_strobe
);

   // reset leaves the block idle and silent
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   // every character is a digit or a minus sign
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.text_char >= b2da_pkg::ASCII_ZERO
                       && rsp_data.text_char <= (b2da_pkg::ASCII_ZERO + 8'd9))
                      || rsp_data.text_char == b2da_pkg::ASCII_MINUS))
      else $error("illegal character");

   // the sign never ends a number
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.text_char == b2da_pkg::ASCII_MINUS)
         |-> !rsp_data.last_char)
      else $error("sign marked last");

   // the last character of an item shows up with the block already free
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_char) |-> !busy)
      else $error("busy after last character");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_data   (rsp_data),
   .rsp_strobe (rsp_strobe)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for binary_to_decimal_ascii_core: a table of directed items,
// then random values, each character checked against typed text or a decimal predictor.
// Depends on b2da_pkg and the converter RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB           = 64;
   localparam int MAX_CHARS    = 20;
   localparam int RANDOM_ITEMS = 350;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 120;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   b2da_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   b2da_pkg::rsp_type rsp_data;

   // characters still owed by the converter, oldest first
   b2da_pkg::rsp_type expected_chars[$];
   b2da_pkg::rsp_type oldest;
   int                mismatches  = 0;
   int                cycle_count = 0;

   // directed table: an empty text means "ask the predictor"
   b2da_pkg::req_type dir_req[$];
   string             dir_text[$];

   binary_to_decimal_ascii_core #(.VALUE_BITS(VB)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decimal text of one item, most significant digit first
   function automatic void push_decimal_text(input b2da_pkg::req_type item);
      logic [63:0] mask;
      logic [63:0] sign_bit;
      logic [63:0] raw;
      logic [63:0] mag;
      logic [7:0]  digits [MAX_CHARS];
      logic        neg;
      int          nd;
      int          count;
      mask     = {64{1'b1}} >> (64 - VB);
      sign_bit = 64'd1 << (VB - 1);
      raw      = item.value & mask;
      neg      = item.signed_mode && ((raw & sign_bit) != 0);
      // magnitude taken unsigned, so the most negative value comes out exact
      mag      = neg ? ((~raw + 64'd1) & mask) : raw;
      nd       = 0;
      count    = 0;
      do begin
         digits[nd] = b2da_pkg::ASCII_ZERO + 8'(mag % 64'd10);
         mag = mag / 64'd10;
         nd++;
      end while (mag != 0 && nd < MAX_CHARS);
      if (neg) begin
         expected_chars.push_back({b2da_pkg::ASCII_MINUS, 1'b0});
         count = 1;
      end
      for (int k = nd - 1; k >= 0 && count < MAX_CHARS; k--) begin
         expected_chars.push_back({digits[k], k == 0});
         count++;
      end
   endfunction

   // text typed into the table, last character flagged
   function automatic void spell_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         expected_chars.push_back({8'(text[i]), i == text.len() - 1});
      end
   endfunction

   function automatic void add_row(input logic [63:0] v, input logic mode, input string text);
      dir_req.push_back({v, mode});
      dir_text.push_back(text);
   endfunction

   // present one item and hold it until the converter takes it
   task automatic send_item(input b2da_pkg::req_type item, input bit steady);
      if (!steady) begin
         while ($urandom_range(99) < 13) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending until every owed character has come out
   task automatic drain;
      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // result checker: the receiver never stalls, so every strobe is a character
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character, expected none, actual %h last %b",
                     $time, rsp_data.text_char, rsp_data.last_char);
            mismatches++;
         end else begin
            oldest = expected_chars.pop_front();
            if (rsp_data.text_char !== oldest.text_char) begin
               $display("%0t: text_char expected %h actual %h",
                        $time, oldest.text_char, rsp_data.text_char);
               mismatches++;
            end
            if (rsp_data.last_char !== oldest.last_char) begin
               $display("%0t: last_char expected %b actual %b",
                        $time, oldest.last_char, rsp_data.last_char);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      b2da_pkg::req_type item;
      logic [63:0]       p;
      int                sel;
      bit                steady;

      // zero, extremes, sign handling, digit-count boundaries
      add_row(64'd0, 1'b0, "0");
      add_row(64'd0, 1'b1, "0");
      add_row(64'd1, 1'b0, "1");
      add_row(64'd9, 1'b1, "9");
      add_row(64'd10, 1'b0, "10");
      add_row(64'd99, 1'b0, "99");
      add_row(64'd100, 1'b1, "100");
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, "18446744073709551615");
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1");
      add_row(64'hFFFF_FFFF_FFFF_FFF6, 1'b1, "-10");
      add_row(64'h8000_0000_0000_0000, 1'b1, "-9223372036854775808");
      add_row(64'h8000_0000_0000_0000, 1'b0, "9223372036854775808");
      add_row(64'h8000_0000_0000_0001, 1'b1, "-9223372036854775807");
      add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, "9223372036854775807");
      add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, "9223372036854775807");
      add_row(64'd10000000000000000000, 1'b0, "10000000000000000000");
      add_row(64'd9999999999999999999, 1'b0, "9999999999999999999");
      add_row(64'd12345678901234567890, 1'b0, "");
      add_row(64'h5555_5555_5555_5555, 1'b1, "");
      add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, "");
      add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, "");
      add_row(64'd1000000000, 1'b1, "");

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_req[i]) begin
         send_item(dir_req[i], 1'b0);
         if (dir_text[i] == "") push_decimal_text(dir_req[i]);
         else spell_text(dir_text[i]);
      end
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0, 1, 2: p = {$urandom, $urandom};
            // random bit length gives every digit count
            3, 4: p = {$urandom, $urandom} >> $urandom_range(0, 63);
            5: p = 64'($urandom_range(0, 999));
            // around powers of ten
            6, 7: begin
               p = 64'd1;
               repeat ($urandom_range(0, 19)) p = p * 64'd10;
               case ($urandom_range(0, 2))
                  0: p = p - 64'd1;
                  2: p = p + 64'd1;
                  default: ;
               endcase
            end
            // near the sign boundary and the all-ones value
            8: begin
               case ($urandom_range(0, 3))
                  0: p = 64'd0;
                  1: p = 64'h8000_0000_0000_0000;
                  2: p = 64'h7FFF_FFFF_FFFF_FFFF;
                  default: p = 64'hFFFF_FFFF_FFFF_FFFF;
               endcase
               p = p ^ 64'($urandom_range(0, 7));
            end
            default: p = 64'd0 - 64'($urandom_range(0, 99999));
         endcase
         item.value       = p;
         item.signed_mode = (sel == 9) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
         steady = (n >= 120 && n < 220);
         send_item(item, steady);
         push_decimal_text(item);
         if (n == 260) drain();
      end

      // wind down
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $display("%0t: %0d expected characters never arrived", $time, expected_chars.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
